[rtl/rgbh_pkg.sv]
// ----------------------------------------------------------------------------
// rgbh_pkg
// Shared types and constants for the RGB histogram with white skip.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbh_pkg;

  // Default store geometry.
  localparam int unsigned BinCountDef  = 256;
  localparam int unsigned CountBitsDef = 24;

  // Widths of the pixel channels and the result count fields.
  localparam int unsigned ChanBits  = 8;
  localparam int unsigned FieldBits = 24;
  localparam int unsigned ChanCount = 3;

  // A channel at this level on all three colors is pure white.
  localparam logic [ChanBits-1:0]  WhiteLevel = 8'd255;
  localparam logic [FieldBits-1:0] FieldMax   = 24'hFFFFFF;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_READ
  } state_e;

endpackage

`default_nettype wire

[rtl/rgbh_ram.sv]
// ----------------------------------------------------------------------------
// rgbh_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbh_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic                re_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/rgb_histogram_white_skip.sv]
// ----------------------------------------------------------------------------
// rgb_histogram_white_skip
// An add reads its bins from the RAMs and writes the increments back from
// ST_ADD; a read loads its result into the output register in the cycle after
// its transfer; a clear walks every bin in ST_CLEAR, and the unused mode code
// leaves the block idle. No new item is taken in ST_ADD, ST_READ or ST_CLEAR,
// and a read also waits while a result sits in the output register. After
// reset the block sweeps all BIN_COUNT bins to zero before its first item.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_histogram_white_skip #(
  parameter int unsigned BIN_COUNT  = rgbh_pkg::BinCountDef,
  parameter int unsigned COUNT_BITS = rgbh_pkg::CountBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write channel: the count_white register.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic                           cfg_data_i,
  // Input item channel.
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     in_mode_i,
  input  wire logic [rgbh_pkg::ChanBits-1:0]  in_red_i,
  input  wire logic [rgbh_pkg::ChanBits-1:0]  in_green_i,
  input  wire logic [rgbh_pkg::ChanBits-1:0]  in_blue_i,
  input  wire logic [rgbh_pkg::ChanBits-1:0]  in_bin_index_i,
  // Result channel.
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [rgbh_pkg::FieldBits-1:0] out_red_count_o,
  output logic      [rgbh_pkg::FieldBits-1:0] out_green_count_o,
  output logic      [rgbh_pkg::FieldBits-1:0] out_blue_count_o
);

  import rgbh_pkg::*;

  localparam int unsigned AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int unsigned IW = (AW > ChanBits) ? AW : ChanBits;
  localparam int unsigned CW = COUNT_BITS;

  // Map an 8-bit channel value onto a bin address of the store's width.
  function automatic logic [AW-1:0] to_addr(input logic [ChanBits-1:0] v);
    logic [IW-1:0] ext;
    ext = IW'(v);
    return ext[AW-1:0];
  endfunction

  // A counter value beyond the result field's range reports the field's maximum.
  function automatic logic [FieldBits-1:0] to_field(input logic [CW-1:0] v);
    logic [FieldBits-1:0] res;
    if (32'(v) > 32'(FieldMax)) begin
      res = FieldMax;
    end else begin
      res = FieldBits'(v);
    end
    return res;
  endfunction

  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_cnt_q, clr_cnt_d;
  logic                   count_white_q;

  // Per-channel write-back context captured at the transfer of an add.
  logic [ChanCount-1:0]   add_en_q;
  logic [AW-1:0]          add_addr_q [ChanCount];
  logic                   rd_zero_q;

  logic                   out_valid_q;
  logic [FieldBits-1:0]   out_cnt_q  [ChanCount];

  logic [ChanBits-1:0]    chan_val   [ChanCount];
  logic [ChanCount-1:0]   ram_we;
  logic [AW-1:0]          ram_waddr  [ChanCount];
  logic [CW-1:0]          ram_wdata  [ChanCount];
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr  [ChanCount];
  logic [CW-1:0]          ram_rdata  [ChanCount];

  logic                   in_accept;
  logic                   load_out;
  logic                   is_white;
  logic                   take_pixel;

  assign chan_val[0] = in_red_i;
  assign chan_val[1] = in_green_i;
  assign chan_val[2] = in_blue_i;

  assign is_white   = (in_red_i == WhiteLevel) && (in_green_i == WhiteLevel) &&
                      (in_blue_i == WhiteLevel);
  assign take_pixel = count_white_q || !is_white;

  // The configuration register can be written at any time; it is only
  // looked at when an add is transferred.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_white_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_white_q <= cfg_data_i;
    end
  end

  // Control: the clearing sweep, item transfers and the RAM write-back.
  // A read is held off while an earlier result still sits in the output
  // register, so the register is always free when the RAM data returns.
  // Adds and clears are taken regardless of the output side.
  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    in_stall_o = 1'b1;
    in_accept  = 1'b0;
    ram_re     = 1'b0;
    load_out   = 1'b0;
    for (int i = 0; i < ChanCount; i++) begin
      ram_we[i]    = 1'b0;
      ram_waddr[i] = add_addr_q[i];
      ram_wdata[i] = (ram_rdata[i] == {CW{1'b1}}) ? ram_rdata[i] : ram_rdata[i] + 1'b1;
      ram_raddr[i] = (in_mode_i == MODE_READ) ? to_addr(in_bin_index_i)
                                              : to_addr(chan_val[i]);
    end

    unique case (state_q)
      ST_CLEAR: begin
        for (int i = 0; i < ChanCount; i++) begin
          ram_we[i]    = 1'b1;
          ram_waddr[i] = clr_cnt_q;
          ram_wdata[i] = '0;
        end
        if (clr_cnt_q == AW'(BIN_COUNT - 1)) begin
          clr_cnt_d = '0;
          state_d   = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        in_stall_o = out_valid_q && (in_mode_i == MODE_READ);
        in_accept  = in_valid_i && !in_stall_o;
        if (in_accept) begin
          case (in_mode_i)
            MODE_ADD: begin
              ram_re  = 1'b1;
              state_d = ST_ADD;
            end
            MODE_READ: begin
              ram_re  = 1'b1;
              state_d = ST_READ;
            end
            MODE_CLEAR: begin
              clr_cnt_d = '0;
              state_d   = ST_CLEAR;
            end
            default: begin
              // The unused mode code changes nothing.
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ADD: begin
        // Write back the saturated increments; channels that were skipped
        // or fell beyond the store leave their bin alone.
        ram_we  = add_en_q;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        load_out = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Context of the item in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_en_q <= '0;
    end else if (in_accept && (in_mode_i == MODE_ADD)) begin
      for (int i = 0; i < ChanCount; i++) begin
        add_en_q[i] <= take_pixel && (32'(chan_val[i]) < BIN_COUNT);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      for (int i = 0; i < ChanCount; i++) begin
        add_addr_q[i] <= to_addr(chan_val[i]);
      end
      rd_zero_q <= (32'(in_bin_index_i) >= BIN_COUNT);
    end
  end

  // One RAM per color histogram.
  for (genvar g = 0; g < ChanCount; g++) begin : g_bins
    rgbh_ram #(
      .Width (CW),
      .Depth (BIN_COUNT)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .waddr_i (ram_waddr[g]),
      .wdata_i (ram_wdata[g]),
      .re_i    (ram_re),
      .raddr_i (ram_raddr[g]),
      .rdata_o (ram_rdata[g])
    );
  end

  // Output register: holds a result until the receiver takes the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int i = 0; i < ChanCount; i++) begin
        out_cnt_q[i] <= rd_zero_q ? '0 : to_field(ram_rdata[i]);
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_red_count_o   = out_cnt_q[0];
  assign out_green_count_o = out_cnt_q[1];
  assign out_blue_count_o  = out_cnt_q[2];

endmodule

`default_nettype wire

[rtl/rgbh_checker.sv]
// ----------------------------------------------------------------------------
// rgbh_checker
// Port-level checks for the RGB histogram, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbh_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic [1:0]                     in_mode_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [rgbh_pkg::FieldBits-1:0] out_red_count_o,
  input wire logic [rgbh_pkg::FieldBits-1:0] out_green_count_o,
  input wire logic [rgbh_pkg::FieldBits-1:0] out_blue_count_o
);

  import rgbh_pkg::*;

  logic in_xfer;
  logic mode_known;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign mode_known = (in_mode_i == MODE_ADD) || (in_mode_i == MODE_READ) ||
                      (in_mode_i == MODE_CLEAR);

  // A stalled result stays valid and keeps its counts.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(out_red_count_o) && $stable(out_green_count_o) &&
      $stable(out_blue_count_o))
    else $error("stalled result changed");

  // Every transfer of a known mode starts work that blocks the next item;
  // the unused mode code is done at once.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && mode_known |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // A read produces its result, by way of ST_READ and the output register.
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_mode_i == MODE_READ) |-> ##2 out_valid_o)
    else $error("read produced no result");

  // An add with an empty output never produces a result.
  a_add_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_mode_i == MODE_ADD) && !out_valid_o |-> ##2 !out_valid_o)
    else $error("add produced a result");

  // A read is never taken while a result waits.
  a_read_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (in_mode_i == MODE_READ) |-> in_stall_o)
    else $error("read taken over a pending result");

endmodule

bind rgb_histogram_white_skip rgbh_checker u_rgbh_checker (.*);

`default_nettype wire

[tb/rgb_histogram_white_skip_tb.sv]
// ----------------------------------------------------------------------------
// rgb_histogram_white_skip_tb
// Self-checking testbench for the RGB histogram with white skip. A behavioral
// copy of the three bin stores predicts the counts of every bin read. Each
// result transfer is checked field by field against the oldest pending read.
// Directed items cover channel extremes, white skip, the unused mode and the
// clear. Random traffic then runs under three sender and receiver idle
// settings, with count_white flipped between phases.
// ----------------------------------------------------------------------------
module rgb_histogram_white_skip_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbh_pkg::*;

  // The mode encoding that the package leaves without a name. The block must
  // accept it and do nothing.
  localparam logic [1:0] ModeUnused = 2'd3;

  // After an item that gives no result the block can still be busy. A clear
  // walks every bin, so this covers the longest such tail with some margin.
  localparam int unsigned DrainCycles = BinCountDef + 8;

  // Generous bound on the whole run. A slow correct run is made up of the reset
  // sweep, about ten clears that each walk the store, and about 450 items
  // stretched by idling on both sides.
  localparam int unsigned CycleLimit = 400000;

  // The three counts of one bin, as the result channel carries them.
  typedef struct packed {
    logic [FieldBits-1:0] red;
    logic [FieldBits-1:0] green;
    logic [FieldBits-1:0] blue;
  } bin_counts_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic                 cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           in_mode_i;
  logic [ChanBits-1:0]  in_red_i;
  logic [ChanBits-1:0]  in_green_i;
  logic [ChanBits-1:0]  in_blue_i;
  logic [ChanBits-1:0]  in_bin_index_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [FieldBits-1:0] out_red_count_o;
  logic [FieldBits-1:0] out_green_count_o;
  logic [FieldBits-1:0] out_blue_count_o;

  // Predicted histogram: one row per color channel, red, green, blue.
  logic [CountBitsDef-1:0] hist [ChanCount][BinCountDef];
  logic                    count_white_q;
  bin_counts_t             pending_reads [$];

  int unsigned sender_gap_pct;
  int unsigned receiver_stall_pct;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  rgb_histogram_white_skip dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_mode_i         (in_mode_i),
    .in_red_i          (in_red_i),
    .in_green_i        (in_green_i),
    .in_blue_i         (in_blue_i),
    .in_bin_index_i    (in_bin_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_red_count_o   (out_red_count_o),
    .out_green_count_o (out_green_count_o),
    .out_blue_count_o  (out_blue_count_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog. A hung handshake or a lost result ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("rgb_histogram_white_skip regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Histogram predictor
  // --------------------------------------------------------------------------

  function automatic void clear_hist();
    foreach (hist[c, i]) begin
      hist[c][i] = '0;
    end
  endfunction

  // One pixel channel lands in its bin. Levels past the store are dropped and
  // a full counter stays at its all-ones value.
  function automatic void tally(int unsigned chan, logic [ChanBits-1:0] level);
    if (level < BinCountDef && hist[chan][level] != '1) begin
      hist[chan][level] = hist[chan][level] + 1'b1;
    end
  endfunction

  // A bin read past the store reports zero; a count beyond the result field's
  // range is clipped to the field's largest value.
  function automatic logic [FieldBits-1:0] field_of(int unsigned chan,
                                                    logic [ChanBits-1:0] idx);
    logic [CountBitsDef-1:0] count;
    if (idx >= BinCountDef) begin
      return '0;
    end
    count = hist[chan][idx];
    if (count > FieldMax) begin
      return FieldMax;
    end
    return FieldBits'(count);
  endfunction

  // Every input transfer updates the predicted histogram. Values are read in
  // the active region of the edge, so they are the ones the block sampled.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_hist();
      count_white_q = 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      case (in_mode_i)
        MODE_ADD: begin
          // Pure white is dropped as a whole unless count_white is set.
          if (count_white_q || !(in_red_i == WhiteLevel && in_green_i == WhiteLevel &&
                                 in_blue_i == WhiteLevel)) begin
            tally(0, in_red_i);
            tally(1, in_green_i);
            tally(2, in_blue_i);
          end
        end
        MODE_READ: begin
          pending_reads.push_back('{red:   field_of(0, in_bin_index_i),
                                    green: field_of(1, in_bin_index_i),
                                    blue:  field_of(2, in_bin_index_i)});
        end
        MODE_CLEAR: begin
          clear_hist();
        end
        default: begin
          // The unused mode changes nothing.
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stall and the checker
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Each result transfer is matched with the oldest read still pending.
  always @(posedge clk_i) begin
    bin_counts_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("result with no read pending: %0d %0d %0d",
                                  out_red_count_o, out_green_count_o, out_blue_count_o));
      end else begin
        want = pending_reads.pop_front();
        if (out_red_count_o !== want.red) begin
          report_mismatch($sformatf("red_count got %0d, want %0d",
                                    out_red_count_o, want.red));
        end
        if (out_green_count_o !== want.green) begin
          report_mismatch($sformatf("green_count got %0d, want %0d",
                                    out_green_count_o, want.green));
        end
        if (out_blue_count_o !== want.blue) begin
          report_mismatch($sformatf("blue_count got %0d, want %0d",
                                    out_blue_count_o, want.blue));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Presents one item and returns at the edge of its transfer with valid
  // still high, so the next item can follow without a bubble. Idle cycles
  // before the item are drawn per cycle from sender_gap_pct.
  task automatic send_item(input logic [1:0] mode, input logic [ChanBits-1:0] red,
                           input logic [ChanBits-1:0] green,
                           input logic [ChanBits-1:0] blue,
                           input logic [ChanBits-1:0] bin_index);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_mode_i      <= mode;
    in_red_i       <= red;
    in_green_i     <= green;
    in_blue_i      <= blue;
    in_bin_index_i <= bin_index;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  // A random channel level or bin number.
  function automatic logic [ChanBits-1:0] any_level();
    return ChanBits'($urandom_range(255));
  endfunction

  // Wrappers fill the fields that a mode ignores with random values.
  task automatic add_pixel(input logic [ChanBits-1:0] red,
                           input logic [ChanBits-1:0] green,
                           input logic [ChanBits-1:0] blue);
    send_item(MODE_ADD, red, green, blue, any_level());
  endtask

  task automatic read_bin(input logic [ChanBits-1:0] bin_index);
    send_item(MODE_READ, any_level(), any_level(), any_level(), bin_index);
  endtask

  task automatic clear_bins();
    send_item(MODE_CLEAR, any_level(), any_level(), any_level(), any_level());
  endtask

  // Holds the sender off until every pending read has been answered, then
  // lets tail_cycles more pass for work that gives no result.
  task automatic settle(input int unsigned tail_cycles);
    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (tail_cycles) @(posedge clk_i);
  endtask

  // count_white is only written with the block idle.
  task automatic write_count_white(input logic value);
    settle(DrainCycles);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    count_white_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Levels are biased toward both ends of the range so that the same bins
  // are hit back to back and read while their counts are moving.
  function automatic logic [ChanBits-1:0] pick_level();
    case ($urandom_range(3))
      0:       return ChanBits'($urandom_range(3));
      1:       return ChanBits'($urandom_range(255, 252));
      default: return ChanBits'($urandom_range(255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Lowest and highest levels on each channel, with repeats of the same bin
  // in consecutive transfers, then reads of four of the bins they touched.
  task automatic test_channel_extremes();
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd0, 8'd128);
    add_pixel(8'd0, 8'd255, 8'd255);
    add_pixel(8'd255, 8'd255, 8'd0);
    add_pixel(8'd254, 8'd1, 8'd255);
    read_bin(8'd0);
    read_bin(8'd255);
    read_bin(8'd128);
    read_bin(8'd254);
  endtask

  // Pure white is skipped while count_white is low and counted once it is
  // set. A pixel one step away from white is always counted.
  task automatic test_white_skip();
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd255, 8'd255, 8'd254);
    read_bin(8'd255);
    write_count_white(1'b1);
    add_pixel(8'd255, 8'd255, 8'd255);
    read_bin(8'd255);
    write_count_white(1'b0);
  endtask

  // The unused mode, with every field at a random value, must leave the
  // histogram as it was and give no result.
  task automatic test_unused_mode();
    send_item(ModeUnused, any_level(), any_level(), any_level(), any_level());
    read_bin(8'd0);
  endtask

  // A clear followed at once by reads and an add: the block has to hold the
  // sender off while it walks the store.
  task automatic test_clear_all();
    clear_bins();
    read_bin(8'd0);
    read_bin(8'd255);
    add_pixel(8'd7, 8'd7, 8'd7);
    read_bin(8'd7);
  endtask

  // Mostly adds and reads on a narrow set of bins, a few clears, the odd
  // pure white pixel and unused mode. Every so often the sender waits for
  // all pending reads to be answered before it goes on.
  task automatic test_random_traffic(input int unsigned items);
    int unsigned sel;
    for (int unsigned n = 0; n < items; n++) begin
      if (n % 64 == 63) begin
        settle(0);
      end
      sel = $urandom_range(99);
      if (sel < 55) begin
        if ($urandom_range(99) < 8) begin
          add_pixel(8'd255, 8'd255, 8'd255);
        end else begin
          add_pixel(pick_level(), pick_level(), pick_level());
        end
      end else if (sel < 92) begin
        read_bin(pick_level());
      end else if (sel < 94) begin
        clear_bins();
      end else begin
        send_item(ModeUnused, any_level(), any_level(), any_level(), any_level());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    // Every input is known from the start, with reset held low at first.
    rst_ni             <= 1'b0;
    cfg_valid_i        <= 1'b0;
    cfg_data_i         <= 1'b0;
    in_valid_i         <= 1'b0;
    in_mode_i          <= MODE_ADD;
    in_red_i           <= '0;
    in_green_i         <= '0;
    in_blue_i          <= '0;
    in_bin_index_i     <= '0;
    out_stall_i        <= 1'b0;
    sender_gap_pct     = 19;
    receiver_stall_pct = 59;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first write also waits out the clearing sweep after reset.
    write_count_white(1'b0);
    test_channel_extremes();
    test_white_skip();
    test_unused_mode();
    test_clear_all();

    // Light sender, heavy receiver, white skipped.
    test_random_traffic(140);

    // Heavy sender, light receiver, white counted.
    write_count_white(1'b1);
    sender_gap_pct     = 59;
    receiver_stall_pct = 19;
    test_random_traffic(140);

    // Neither side idles, white skipped again.
    write_count_white(1'b0);
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    test_random_traffic(140);

    settle(DrainCycles);
    if (mismatch_count == 0) begin
      $display("rgb_histogram_white_skip regression: pass");
    end else begin
      $display("rgb_histogram_white_skip regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rgbh_pkg.sv
rtl/rgbh_ram.sv
rtl/rgb_histogram_white_skip.sv
rtl/rgbh_checker.sv
tb/rgb_histogram_white_skip_tb.sv
